/* rtl/lpcf_pkg.sv */
`timescale 1ns / 1ps

package lpcf_pkg;

  // field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgCrcPoly  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCrcStart = 2'd1;

  // configuration reset values
  localparam logic [ByteW-1:0] CrcPolyRst  = 8'h07;
  localparam logic [ByteW-1:0] CrcStartRst = 8'h00;

  // frame phase codes
  localparam logic [1:0] PhaseLength = 2'd0;
  localparam logic [1:0] PhaseData   = 2'd1;
  localparam logic [1:0] PhaseCrc    = 2'd2;

  // role of a byte within its frame
  typedef enum logic [1:0] {
    RoleLength = 2'd0,
    RoleData   = 2'd1,
    RoleCrc    = 2'd2
  } role_e;

  // one result, as it travels from the sequencer to the output register
  typedef struct packed {
    logic [ByteW-1:0] byte_out;
    role_e            byte_role;
    logic [ByteW-1:0] frame_length;
    logic             crc_good;
    logic [ByteW-1:0] computed_crc;
    logic             frame_end;
  } res_t;

endpackage

/* rtl/lpcf_if.sv */
`timescale 1ns / 1ps

// received byte stream
interface lpcf_byte_if;
  logic                        valid;
  logic                        ready;
  logic [lpcf_pkg::ByteW-1:0]  byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

// per-byte result stream
interface lpcf_res_if;
  logic                        valid;
  logic                        ready;
  logic [lpcf_pkg::ByteW-1:0]  byte_out;
  lpcf_pkg::role_e             byte_role;
  logic [lpcf_pkg::ByteW-1:0]  frame_length;
  logic                        crc_good;
  logic [lpcf_pkg::ByteW-1:0]  computed_crc;
  logic                        frame_end;

  modport source (output valid, output byte_out, output byte_role, output frame_length,
                  output crc_good, output computed_crc, output frame_end, input ready);
  modport sink   (input valid, input byte_out, input byte_role, input frame_length,
                  input crc_good, input computed_crc, input frame_end, output ready);
endinterface

// configuration register writes
interface lpcf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lpcf_pkg::CfgIdxW-1:0]  index;
  logic [lpcf_pkg::ByteW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/lpcf_crc8.sv */
`timescale 1ns / 1ps

module lpcf_crc8 (
  input  logic [lpcf_pkg::ByteW-1:0] crc_i,
  input  logic [lpcf_pkg::ByteW-1:0] data_i,
  input  logic [lpcf_pkg::ByteW-1:0] poly_i,
  output logic [lpcf_pkg::ByteW-1:0] crc_o
);

  // msb-first byte update, one shift per bit, unrolled into xor logic
  always_comb begin
    logic [lpcf_pkg::ByteW-1:0] c;
    c = crc_i ^ data_i;
    for (int k = 0; k < lpcf_pkg::ByteW; k++) begin
      if (c[lpcf_pkg::ByteW-1]) begin
        c = {c[lpcf_pkg::ByteW-2:0], 1'b0} ^ poly_i;
      end else begin
        c = {c[lpcf_pkg::ByteW-2:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

/* rtl/lpcf_seq.sv */
`timescale 1ns / 1ps

module lpcf_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [lpcf_pkg::ByteW-1:0] byte_i,
  input  logic [lpcf_pkg::ByteW-1:0] poly_i,
  input  logic [lpcf_pkg::ByteW-1:0] start_i,
  output lpcf_pkg::res_t             res_o
);

  logic [1:0]                 phase_q, phase_d;
  logic [lpcf_pkg::ByteW-1:0] length_q, length_d;
  logic [lpcf_pkg::ByteW-1:0] left_q, left_d;
  logic [lpcf_pkg::ByteW-1:0] crc_q, crc_d;
  logic [lpcf_pkg::ByteW-1:0] crc_upd;

  lpcf_crc8 u_crc8 (
    .crc_i  (crc_q),
    .data_i (byte_i),
    .poly_i (poly_i),
    .crc_o  (crc_upd)
  );

  // next frame state and the result for the byte on offer
  always_comb begin
    phase_d  = phase_q;
    length_d = length_q;
    left_d   = left_q;
    crc_d    = crc_q;

    res_o.byte_out  = byte_i;
    res_o.crc_good  = 1'b0;
    res_o.frame_end = 1'b0;

    unique case (phase_q)
      lpcf_pkg::PhaseData: begin
        res_o.byte_role = lpcf_pkg::RoleData;
        crc_d           = crc_upd;
        left_d          = left_q - 8'd1;
        if (left_q == 8'd1) begin
          phase_d = lpcf_pkg::PhaseCrc;
        end
      end
      lpcf_pkg::PhaseCrc: begin
        res_o.byte_role = lpcf_pkg::RoleCrc;
        res_o.crc_good  = (byte_i == crc_q);
        res_o.frame_end = 1'b1;
        phase_d         = lpcf_pkg::PhaseLength;
      end
      // length byte, also the unused phase code
      default: begin
        res_o.byte_role = lpcf_pkg::RoleLength;
        length_d        = byte_i;
        left_d          = byte_i;
        crc_d           = start_i;
        phase_d         = (byte_i == 8'd0) ? lpcf_pkg::PhaseCrc : lpcf_pkg::PhaseData;
      end
    endcase

    res_o.frame_length = length_d;
    res_o.computed_crc = crc_d;
  end

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= lpcf_pkg::PhaseLength;
      length_q <= '0;
      left_q   <= '0;
      crc_q    <= lpcf_pkg::CrcStartRst;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      length_q <= length_d;
      left_q   <= left_d;
      crc_q    <= crc_d;
    end
  end

endmodule

/* rtl/lpcf_out_reg.sv */
`timescale 1ns / 1ps

module lpcf_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  lpcf_pkg::res_t res_i,
  input  logic           out_ready_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output lpcf_pkg::res_t res_o
);

  logic           valid_q;
  lpcf_pkg::res_t res_q;

  // a new request may enter when the register is empty or drains this cycle
  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

/* rtl/length_prefixed_crc8_frame_checker.sv */
`timescale 1ns / 1ps

// channel  direction  carries
// in_i     sink       byte_in, one received byte per request
// res_o    source     byte_out, byte_role, frame_length, crc_good, computed_crc, frame_end
// cfg_i    sink       index, data: 0 crc polynomial, 1 crc start value
//
// one byte per cycle while the result register is drained; each result appears in the cycle after its byte is taken,
// from a single result register fed by the frame sequencer and crc-8 xor logic.
// reset returns to waiting for a length byte, polynomial 0x07, start value 0x00.
// a stalled result blocks input only while the result register stays full;
// configuration writes are always taken, unknown indexes are dropped.

module length_prefixed_crc8_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  lpcf_byte_if.sink   in_i,
  lpcf_res_if.source  res_o,
  lpcf_cfg_if.sink    cfg_i
);

  logic [lpcf_pkg::ByteW-1:0] poly_q;
  logic [lpcf_pkg::ByteW-1:0] start_q;
  logic                       in_fire;
  logic                       in_ready;
  lpcf_pkg::res_t             res_next;
  lpcf_pkg::res_t             res_cur;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q  <= lpcf_pkg::CrcPolyRst;
      start_q <= lpcf_pkg::CrcStartRst;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == lpcf_pkg::CfgCrcPoly) begin
        poly_q <= cfg_i.data;
      end
      if (cfg_i.index == lpcf_pkg::CfgCrcStart) begin
        start_q <= cfg_i.data;
      end
    end
  end

  // input handshake
  assign in_i.ready = in_ready;
  assign in_fire    = in_i.valid && in_ready;

  lpcf_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_fire),
    .byte_i   (in_i.byte_in),
    .poly_i   (poly_q),
    .start_i  (start_q),
    .res_o    (res_next)
  );

  lpcf_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_fire),
    .res_i       (res_next),
    .out_ready_i (res_o.ready),
    .in_ready_o  (in_ready),
    .out_valid_o (res_o.valid),
    .res_o       (res_cur)
  );

  // result fields
  assign res_o.byte_out     = res_cur.byte_out;
  assign res_o.byte_role    = res_cur.byte_role;
  assign res_o.frame_length = res_cur.frame_length;
  assign res_o.crc_good     = res_cur.crc_good;
  assign res_o.computed_crc = res_cur.computed_crc;
  assign res_o.frame_end    = res_cur.frame_end;

  // a taken byte always shows up as a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> res_o.valid)
    else $error("accepted byte produced no result");

  // frame end only on the crc byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.frame_end |-> res_o.byte_role == lpcf_pkg::RoleCrc)
    else $error("frame end on a non-crc byte");

  // crc check flag only on the crc byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.crc_good |-> res_o.frame_end)
    else $error("crc good outside the crc byte");

endmodule

/* dv/length_prefixed_crc8_frame_checker_tb.sv */
`timescale 1ns / 1ps

module length_prefixed_crc8_frame_checker_tb;

  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned NumPhases   = 6;
  localparam int unsigned NumDirRows  = 21;

  // indexes beyond the register file, writes there must be dropped
  localparam logic [lpcf_pkg::CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [lpcf_pkg::CfgIdxW-1:0] CfgSpareB = 2'd3;

  // crc settings of the fixed phases, later phases pick their own
  localparam logic [lpcf_pkg::ByteW-1:0] PolySet  [4] = '{8'h07, 8'h00, 8'hFF, 8'h31};
  localparam logic [lpcf_pkg::ByteW-1:0] StartSet [4] = '{8'h00, 8'h00, 8'hFF, 8'hFF};
  localparam int PhaseItems [NumPhases] = '{50, 50, 50, 300, 50, 50};

  typedef enum logic [1:0] {
    StallNone    = 2'd0,
    StallRandom  = 2'd1,
    StallPattern = 2'd2
  } stall_e;

  typedef struct {
    logic [lpcf_pkg::ByteW-1:0] stim;
    bit                         typed;
    lpcf_pkg::res_t             exp;
  } dir_row_t;

  // opening sequence at reset settings (poly 0x07, start 0x00)
  dir_row_t dir_rows [NumDirRows] = '{
    '{8'h00, 1'b1, '{8'h00, lpcf_pkg::RoleLength, 8'h00, 1'b0, 8'h00, 1'b0}},
    '{8'h00, 1'b1, '{8'h00, lpcf_pkg::RoleCrc,    8'h00, 1'b1, 8'h00, 1'b1}},
    '{8'h00, 1'b1, '{8'h00, lpcf_pkg::RoleLength, 8'h00, 1'b0, 8'h00, 1'b0}},
    '{8'hFF, 1'b1, '{8'hFF, lpcf_pkg::RoleCrc,    8'h00, 1'b0, 8'h00, 1'b1}},
    '{8'h01, 1'b1, '{8'h01, lpcf_pkg::RoleLength, 8'h01, 1'b0, 8'h00, 1'b0}},
    '{8'h00, 1'b1, '{8'h00, lpcf_pkg::RoleData,   8'h01, 1'b0, 8'h00, 1'b0}},
    '{8'h00, 1'b1, '{8'h00, lpcf_pkg::RoleCrc,    8'h01, 1'b1, 8'h00, 1'b1}},
    '{8'h01, 1'b1, '{8'h01, lpcf_pkg::RoleLength, 8'h01, 1'b0, 8'h00, 1'b0}},
    '{8'h80, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h03, 1'b1, '{8'h03, lpcf_pkg::RoleLength, 8'h03, 1'b0, 8'h00, 1'b0}},
    '{8'hFF, 1'b0, '0},
    '{8'h55, 1'b0, '0},
    '{8'hAA, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h02, 1'b1, '{8'h02, lpcf_pkg::RoleLength, 8'h02, 1'b0, 8'h00, 1'b0}},
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b1, '{8'h00, lpcf_pkg::RoleLength, 8'h00, 1'b0, 8'h00, 1'b0}},
    '{8'h80, 1'b1, '{8'h80, lpcf_pkg::RoleCrc,    8'h00, 1'b0, 8'h00, 1'b1}}
  };

  logic clk_i;
  logic rst_ni;

  lpcf_byte_if byte_ch ();
  lpcf_res_if  res_ch ();
  lpcf_cfg_if  cfg_ch ();

  length_prefixed_crc8_frame_checker dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  // frame tracker state and register copies
  logic [1:0]                 frame_phase_q;
  logic [lpcf_pkg::ByteW-1:0] frame_len_q;
  logic [lpcf_pkg::ByteW-1:0] bytes_left_q;
  logic [lpcf_pkg::ByteW-1:0] frame_crc_q;
  logic [lpcf_pkg::ByteW-1:0] crc_poly_q;
  logic [lpcf_pkg::ByteW-1:0] crc_start_q;

  lpcf_pkg::res_t frame_results_q [$];
  lpcf_pkg::res_t got_r;
  lpcf_pkg::res_t want_r;
  int     err_count = 0;
  int     res_count = 0;
  int     idle_cycles;
  bit     gaps_on;
  int     burst_left;
  stall_e stall_mode;
  logic [15:0] stall_seed;
  logic [3:0]  stall_pos;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // msb-first crc-8 over one byte
  function automatic logic [lpcf_pkg::ByteW-1:0] crc8_next(
      input logic [lpcf_pkg::ByteW-1:0] crc,
      input logic [lpcf_pkg::ByteW-1:0] b,
      input logic [lpcf_pkg::ByteW-1:0] poly);
    logic [lpcf_pkg::ByteW-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ poly) : (c << 1);
    end
    return c;
  endfunction

  // advance the frame tracker by one byte and give the result it implies
  function automatic lpcf_pkg::res_t frame_result(input logic [lpcf_pkg::ByteW-1:0] b);
    lpcf_pkg::res_t r;
    r = '0;
    r.byte_out = b;
    case (frame_phase_q)
      lpcf_pkg::PhaseData: begin
        r.byte_role  = lpcf_pkg::RoleData;
        frame_crc_q  = crc8_next(frame_crc_q, b, crc_poly_q);
        bytes_left_q = bytes_left_q - 1'b1;
        if (bytes_left_q == '0) frame_phase_q = lpcf_pkg::PhaseCrc;
      end
      lpcf_pkg::PhaseCrc: begin
        r.byte_role   = lpcf_pkg::RoleCrc;
        r.crc_good    = (b == frame_crc_q);
        r.frame_end   = 1'b1;
        frame_phase_q = lpcf_pkg::PhaseLength;
      end
      default: begin
        r.byte_role   = lpcf_pkg::RoleLength;
        frame_len_q   = b;
        bytes_left_q  = b;
        frame_crc_q   = crc_start_q;
        frame_phase_q = (b == '0) ? lpcf_pkg::PhaseCrc : lpcf_pkg::PhaseData;
      end
    endcase
    r.frame_length = frame_len_q;
    r.computed_crc = frame_crc_q;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [lpcf_pkg::ByteW-1:0] got,
                                 input logic [lpcf_pkg::ByteW-1:0] want);
    $display("result %0d: %s got 0x%02h, expected 0x%02h", res_count, what, got, want);
    err_count++;
  endtask

  // one byte request, followed by a gap when gaps are on and the burst runs out
  task automatic send_byte(input logic [lpcf_pkg::ByteW-1:0] b, input bit typed,
                           input lpcf_pkg::res_t typed_res);
    lpcf_pkg::res_t pred;
    byte_ch.valid   <= 1'b1;
    byte_ch.byte_in <= b;
    do @(posedge clk_i); while (!byte_ch.ready);
    pred = frame_result(b);
    frame_results_q.push_back(typed ? typed_res : pred);
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        byte_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        burst_left = $urandom_range(1, 24);
      end
    end
  endtask

  task automatic write_reg(input logic [lpcf_pkg::CfgIdxW-1:0] idx,
                           input logic [lpcf_pkg::ByteW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == lpcf_pkg::CfgCrcPoly) crc_poly_q = val;
    else if (idx == lpcf_pkg::CfgCrcStart) crc_start_q = val;
    @(posedge clk_i);
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // result side back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_pos    <= '0;
      res_ch.ready <= 1'b0;
    end else begin
      stall_pos <= stall_pos + 1'b1;
      case (stall_mode)
        StallNone:   res_ch.ready <= 1'b1;
        StallRandom: res_ch.ready <= 1'($urandom_range(0, 1));
        default:     res_ch.ready <= stall_seed[stall_pos];
      endcase
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got_r = '{res_ch.byte_out, res_ch.byte_role, res_ch.frame_length, res_ch.crc_good,
                res_ch.computed_crc, res_ch.frame_end};
      if (frame_results_q.size() == 0) begin
        report_mismatch("unexpected result, byte_out", got_r.byte_out, 8'h00);
      end else begin
        want_r = frame_results_q.pop_front();
        if (got_r.byte_out != want_r.byte_out)
          report_mismatch("byte_out", got_r.byte_out, want_r.byte_out);
        if (got_r.byte_role != want_r.byte_role)
          report_mismatch("byte_role", {6'b0, got_r.byte_role}, {6'b0, want_r.byte_role});
        if (got_r.frame_length != want_r.frame_length)
          report_mismatch("frame_length", got_r.frame_length, want_r.frame_length);
        if (got_r.crc_good != want_r.crc_good)
          report_mismatch("crc_good", {7'b0, got_r.crc_good}, {7'b0, want_r.crc_good});
        if (got_r.computed_crc != want_r.computed_crc)
          report_mismatch("computed_crc", got_r.computed_crc, want_r.computed_crc);
        if (got_r.frame_end != want_r.frame_end)
          report_mismatch("frame_end", {7'b0, got_r.frame_end}, {7'b0, want_r.frame_end});
      end
      res_count++;
    end
  end

  // watchdog on cycles without any request moving
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int                         ph;
    int                         n;
    logic [lpcf_pkg::ByteW-1:0] b;
    bit                         long_pending;

    rst_ni          = 1'b0;
    byte_ch.valid   = 1'b0;
    byte_ch.byte_in = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    stall_mode      = StallNone;
    stall_seed      = '1;
    gaps_on         = 1'b1;
    burst_left      = 1;
    frame_phase_q   = lpcf_pkg::PhaseLength;
    frame_len_q     = '0;
    bytes_left_q    = '0;
    crc_poly_q      = lpcf_pkg::CrcPolyRst;
    crc_start_q     = lpcf_pkg::CrcStartRst;
    frame_crc_q     = lpcf_pkg::CrcStartRst;

    repeat (10) @(posedge clk_i);
    rst_ni     <= 1'b1;
    stall_mode <= StallRandom;
    @(posedge clk_i);

    // directed opening at reset settings
    foreach (dir_rows[i]) send_byte(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].exp);
    wait_drained();

    // random frames, settings changed between phases, often mid-frame
    for (ph = 0; ph < NumPhases; ph++) begin
      if (ph < 4) begin
        write_reg(lpcf_pkg::CfgCrcPoly, PolySet[ph]);
        write_reg(lpcf_pkg::CfgCrcStart, StartSet[ph]);
      end else begin
        write_reg(lpcf_pkg::CfgCrcPoly, 8'($urandom_range(0, 255)));
        write_reg(lpcf_pkg::CfgCrcStart, 8'($urandom_range(0, 255)));
      end
      if (ph > 0) write_reg(ph[0] ? CfgSpareA : CfgSpareB, 8'($urandom_range(0, 255)));
      stall_mode   <= stall_e'(ph % 3);
      stall_seed   <= 16'($urandom_range(0, 65535)) | 16'h0001;
      gaps_on      = (ph != 2);
      burst_left   = $urandom_range(1, 24);
      long_pending = (ph == 3);
      for (n = 0; n < PhaseItems[ph]; n++) begin
        case (frame_phase_q)
          lpcf_pkg::PhaseData: b = 8'($urandom_range(0, 255));
          lpcf_pkg::PhaseCrc: begin
            b = ($urandom_range(0, 99) < 80) ? frame_crc_q : 8'($urandom_range(0, 255));
          end
          default: begin
            // one longest frame in the long phase, otherwise mostly short ones
            if (long_pending) begin
              b = 8'hFF;
              long_pending = 1'b0;
            end else if ($urandom_range(0, 3) != 0) begin
              b = 8'($urandom_range(0, 8));
            end else begin
              b = 8'($urandom_range(9, 40));
            end
          end
        endcase
        send_byte(b, 1'b0, '0);
      end
      wait_drained();
    end

    if (err_count == 0 && frame_results_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* length_prefixed_crc8_frame_checker.f */
rtl/lpcf_pkg.sv
rtl/lpcf_if.sv
rtl/lpcf_crc8.sv
rtl/lpcf_seq.sv
rtl/lpcf_out_reg.sv
rtl/length_prefixed_crc8_frame_checker.sv
dv/length_prefixed_crc8_frame_checker_tb.sv
